FILE: sv/sdcle_pkg.sv
// shared types, constants and the crc7 helper for the sd command line engine
// no dependencies; imported by sdcle_core and sd_command_line_engine

package sdcle_pkg;

   // stream payload widths, padded to whole bytes
   localparam int ReqDataW = 56;
   localparam int RspDataW = 80;

   // expected response kinds
   localparam logic [2:0] KIND_R2 = 3'd1;
   localparam logic [2:0] KIND_R3 = 3'd2;
   localparam logic [2:0] KIND_R7 = 3'd4;

   // error codes
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_NO_RESP  = 2'd1;
   localparam logic [1:0] ERR_BAD_START = 2'd2;
   localparam logic [1:0] ERR_BAD_STOP = 2'd3;

   // one input beat, unpacked
   typedef struct packed {
      logic        sclk_rise;
      logic        sclk_fall;
      logic        cmd_in;
      logic        error_pending;
      logic        timeout_tick;
      logic        force_low;
      logic        req_valid;
      logic [5:0]  req_index;
      logic [31:0] req_argument;
      logic [2:0]  req_resp_kind;
      logic        resp_ack;
   } sdcle_in_type;

   // one result beat, unpacked
   typedef struct packed {
      logic        cmd_out;
      logic        drive_enable;
      logic        chip_select;
      logic        req_accept;
      logic        resp_avail;
      logic [5:0]  resp_index;
      logic [31:0] resp_register;
      logic [6:0]  crc_received;
      logic [6:0]  crc_computed;
      logic [14:0] spi_status;
      logic        timeout_enable;
      logic [1:0]  error_code;
   } sdcle_out_type;

   // crc7 x^7+x^3+1, one bit
   function automatic logic [6:0] crc7_step(input logic [6:0] crc, input logic bit_in);
      logic [6:0] c;
      begin
         c = {crc[5:0], 1'b0};
         if (crc[6] ^ bit_in) begin
            c = c ^ 7'h09;
         end
         return c;
      end
   endfunction

endpackage

FILE: sv/sd_command_line_engine.sv
// A result beat is registered and appears in the cycle after its request beat is accepted.
// Throughput: one beat per cycle; req_tready stays high while the result register
// is empty or being taken in the same cycle, so result-side backpressure sets the pace.
// Reset (synchronous, active high): sequencer idle, CMD driven high, chip select
// high, result register empty, spi_mode cleared to native SD framing.
// Depends on sdcle_pkg and sdcle_core.

module sd_command_line_engine (
   input  logic                          clock,
   input  logic                          reset,
   // request stream
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // [0] sclk_rise [1] sclk_fall [2] cmd_in [3] error_pending [4] timeout_tick
   // [5] force_low [6] req_valid [12:7] req_index [44:13] req_argument
   // [47:45] req_resp_kind [48] resp_ack, rest zero
   input  logic [sdcle_pkg::ReqDataW-1:0] req_tdata,
   // result stream
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [0] cmd_out [1] drive_enable [2] chip_select [3] req_accept [4] resp_avail
   // [10:5] resp_index [42:11] resp_register [49:43] crc_received
   // [56:50] crc_computed [71:57] spi_status [72] timeout_enable
   // [74:73] error_code, rest zero
   output logic [sdcle_pkg::RspDataW-1:0] rsp_tdata,
   // register write channel: spi_mode
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_data
);
   import sdcle_pkg::*;

   logic                spi_mode_ff;
   logic                rsp_valid_ff;
   logic [RspDataW-1:0] rsp_data_ff;
   logic                step;
   sdcle_in_type        in_beat;
   sdcle_out_type       out_beat;
   logic [RspDataW-1:0] out_packed;

   // handshake: accept while the result slot is free or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign step       = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // unpack request beat
   always_comb begin
      in_beat.sclk_rise     = req_tdata[0];
      in_beat.sclk_fall     = req_tdata[1];
      in_beat.cmd_in        = req_tdata[2];
      in_beat.error_pending = req_tdata[3];
      in_beat.timeout_tick  = req_tdata[4];
      in_beat.force_low     = req_tdata[5];
      in_beat.req_valid     = req_tdata[6];
      in_beat.req_index     = req_tdata[12:7];
      in_beat.req_argument  = req_tdata[44:13];
      in_beat.req_resp_kind = req_tdata[47:45];
      in_beat.resp_ack      = req_tdata[48];
   end

   sdcle_core u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .spi_mode (spi_mode_ff),
      .in_beat  (in_beat),
      .out_beat (out_beat)
   );

   // pack result beat
   assign out_packed = {5'd0,
                        out_beat.error_code,
                        out_beat.timeout_enable,
                        out_beat.spi_status,
                        out_beat.crc_computed,
                        out_beat.crc_received,
                        out_beat.resp_register,
                        out_beat.resp_index,
                        out_beat.resp_avail,
                        out_beat.req_accept,
                        out_beat.chip_select,
                        out_beat.drive_enable,
                        out_beat.cmd_out};

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= out_packed;
      end
   end

   // mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         spi_mode_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         spi_mode_ff <= csr_data;
      end
   end

endmodule

FILE: sv/sdcle_core.sv
// command line sequencer: frame transmit, response receive, crc7 and flags
// depends on sdcle_pkg; one step per accepted beat

module sdcle_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic                    spi_mode,
   input  sdcle_pkg::sdcle_in_type  in_beat,
   output sdcle_pkg::sdcle_out_type out_beat
);
   import sdcle_pkg::*;

   // sequencer phases
   localparam logic [3:0] PH_IDLE     = 4'd0;
   localparam logic [3:0] PH_TX_BODY  = 4'd1;
   localparam logic [3:0] PH_TX_CRC   = 4'd2;
   localparam logic [3:0] PH_TX_STOP  = 4'd3;
   localparam logic [3:0] PH_WAIT     = 4'd4;
   localparam logic [3:0] PH_TRANS    = 4'd5;
   localparam logic [3:0] PH_MIRROR   = 4'd6;
   localparam logic [3:0] PH_REG      = 4'd7;
   localparam logic [3:0] PH_LONG     = 4'd8;
   localparam logic [3:0] PH_RX_CRC   = 4'd9;
   localparam logic [3:0] PH_RX_STOP  = 4'd10;
   localparam logic [3:0] PH_SPI_R1   = 4'd11;
   localparam logic [3:0] PH_SPI_R2   = 4'd12;
   localparam logic [3:0] PH_SPI_DATA = 4'd13;
   localparam logic [3:0] PH_PAUSE    = 4'd15;

   logic [3:0]  phase_ff, phase_in;
   logic [39:0] tx_ff, tx_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [2:0]  kind_ff, kind_in;
   logic [5:0]  hidx_ff, hidx_in;
   logic [5:0]  idx_ff, idx_in;
   logic [31:0] reg_ff, reg_in;
   logic [14:0] status_ff, status_in;
   logic [6:0]  crc_ff, crc_in;
   logic        clr_ff, clr_in;
   logic [6:0]  snap_ff, snap_in;
   logic [6:0]  crx_ff, crx_in;
   logic        cs_ff, cs_in;
   logic        dir_ff, dir_in;
   logic        wdog_ff, wdog_in;
   logic        valid_ff, valid_in;
   logic [1:0]  err_ff, err_in;

   logic        rise, fall, cmd;
   logic        feed;
   logic        dat;
   logic [6:0]  wb;
   logic [39:0] tx_shl;

   assign rise   = in_beat.sclk_rise;
   assign fall   = in_beat.sclk_fall;
   assign cmd    = in_beat.cmd_in;
   assign tx_shl = {tx_ff[38:0], 1'b1};

   // result fields come from state before this beat
   always_comb begin
      out_beat.cmd_out        = tx_ff[39];
      out_beat.drive_enable   = dir_ff;
      out_beat.chip_select    = cs_ff;
      out_beat.req_accept     = fall && (phase_ff == PH_IDLE) && !in_beat.error_pending;
      out_beat.resp_avail     = valid_ff;
      out_beat.resp_index     = idx_ff;
      out_beat.resp_register  = reg_ff;
      out_beat.crc_received   = crx_ff;
      out_beat.crc_computed   = snap_ff;
      out_beat.spi_status     = status_ff;
      out_beat.timeout_enable = wdog_ff;
      out_beat.error_code     = err_ff;
   end

   // crc feed, taken from the phase before the update
   always_comb begin
      feed = 1'b0;
      if (fall) begin
         feed = (phase_ff == PH_TX_BODY);
      end else if (rise) begin
         feed = (phase_ff == PH_WAIT && !cmd && !spi_mode) || phase_ff == PH_TRANS ||
                phase_ff == PH_MIRROR || phase_ff == PH_REG;
      end
      dat = (phase_ff < PH_WAIT || phase_ff == PH_PAUSE) ? tx_ff[39] : cmd;
      wb  = clr_ff ? 7'd0 : crc_ff;
      if (feed) begin
         wb = crc7_step(wb, dat);
      end
   end

   // next state
   always_comb begin
      phase_in  = phase_ff;
      tx_in     = tx_ff;
      cnt_in    = cnt_ff;
      kind_in   = kind_ff;
      hidx_in   = hidx_ff;
      idx_in    = idx_ff;
      reg_in    = reg_ff;
      status_in = status_ff;
      crc_in    = wb;
      clr_in    = clr_ff;
      snap_in   = snap_ff;
      crx_in    = crx_ff;
      cs_in     = cs_ff;
      dir_in    = dir_ff;
      wdog_in   = wdog_ff;
      valid_in  = valid_ff && !in_beat.resp_ack;
      err_in    = ERR_NONE;

      if (fall) begin
         case (phase_ff)
            PH_IDLE: begin
               tx_in   = in_beat.force_low ? 40'd0 : {40{1'b1}};
               wdog_in = 1'b0;
               cs_in   = 1'b1;
               dir_in  = 1'b1;
               clr_in  = 1'b1;
               if (!in_beat.error_pending && in_beat.req_valid) begin
                  cs_in    = 1'b0;
                  hidx_in  = in_beat.req_index;
                  kind_in  = in_beat.req_resp_kind;
                  tx_in    = {2'b01, in_beat.req_index, in_beat.req_argument};
                  cnt_in   = 7'd39;
                  clr_in   = 1'b0;
                  phase_in = PH_TX_BODY;
               end
            end
            PH_TX_BODY: begin
               tx_in = tx_shl;
               if (cnt_ff != 7'd0) begin
                  cnt_in = cnt_ff - 7'd1;
               end else begin
                  phase_in = PH_TX_CRC;
                  snap_in  = wb;
                  tx_in    = {wb, 1'b1, tx_shl[31:0]};
                  cnt_in   = 7'd6;
                  clr_in   = 1'b1;
               end
            end
            PH_TX_CRC: begin
               tx_in = tx_shl;
               if (cnt_ff != 7'd0) begin
                  cnt_in = cnt_ff - 7'd1;
               end else begin
                  phase_in = PH_TX_STOP;
               end
            end
            PH_TX_STOP: begin
               phase_in = PH_WAIT;
               dir_in   = 1'b0;
               wdog_in  = 1'b1;
               clr_in   = 1'b0;
            end
            PH_PAUSE: begin
               clr_in = 1'b1;
               cs_in  = 1'b1;
               dir_in = 1'b1;
               if (cnt_ff != 7'd0) begin
                  cnt_in = cnt_ff - 7'd1;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
            default: begin
            end
         endcase
      end else if (rise) begin
         case (phase_ff)
            PH_WAIT: begin
               if (!cmd) begin
                  if (!spi_mode) begin
                     phase_in = PH_TRANS;
                  end else begin
                     phase_in  = PH_SPI_R1;
                     cnt_in    = 7'd6;
                     idx_in    = hidx_ff;
                     status_in = 15'd0;
                     reg_in    = 32'd0;
                  end
               end else if (in_beat.timeout_tick) begin
                  wdog_in  = 1'b0;
                  valid_in = 1'b1;
                  err_in   = ERR_NO_RESP;
                  phase_in = PH_IDLE;
               end
            end
            PH_TRANS: begin
               if (!cmd) begin
                  phase_in = PH_MIRROR;
                  idx_in   = 6'd0;
                  cnt_in   = 7'd5;
               end else begin
                  err_in   = ERR_BAD_START;
                  phase_in = PH_IDLE;
                  valid_in = 1'b1;
               end
            end
            PH_MIRROR: begin
               idx_in = {idx_ff[4:0], cmd};
               if (cnt_ff != 7'd0) begin
                  cnt_in = cnt_ff - 7'd1;
               end else if (kind_ff == KIND_R2) begin
                  cnt_in   = 7'd119;
                  phase_in = PH_LONG;
               end else begin
                  cnt_in   = 7'd31;
                  phase_in = PH_REG;
               end
            end
            PH_REG, PH_LONG: begin
               if (phase_ff == PH_REG) begin
                  reg_in = {reg_ff[30:0], cmd};
               end
               if (cnt_ff != 7'd0) begin
                  cnt_in = cnt_ff - 7'd1;
               end else begin
                  snap_in  = wb;
                  cnt_in   = 7'd6;
                  phase_in = PH_RX_CRC;
               end
            end
            PH_RX_CRC: begin
               crx_in = {crx_ff[5:0], cmd};
               if (cnt_ff != 7'd0) begin
                  cnt_in = cnt_ff - 7'd1;
               end else begin
                  phase_in = PH_RX_STOP;
               end
            end
            PH_RX_STOP: begin
               if (!cmd) begin
                  err_in = ERR_BAD_STOP;
               end
               phase_in = PH_PAUSE;
               cnt_in   = 7'd2;
               valid_in = 1'b1;
            end
            PH_SPI_R1: begin
               status_in = {status_ff[13:8], cmd, status_ff[7:0]};
               if (cnt_ff != 7'd0) begin
                  cnt_in = cnt_ff - 7'd1;
               end else if (kind_ff == KIND_R2) begin
                  cnt_in   = 7'd7;
                  phase_in = PH_SPI_R2;
               end else if (kind_ff == KIND_R3 || kind_ff == KIND_R7) begin
                  cnt_in   = 7'd31;
                  phase_in = PH_SPI_DATA;
               end else begin
                  phase_in = PH_PAUSE;
                  cnt_in   = 7'd2;
                  valid_in = 1'b1;
               end
            end
            PH_SPI_R2: begin
               status_in = {status_ff[14:8], status_ff[6:0], cmd};
               if (cnt_ff != 7'd0) begin
                  cnt_in = cnt_ff - 7'd1;
               end else begin
                  phase_in = PH_PAUSE;
                  cnt_in   = 7'd2;
                  valid_in = 1'b1;
               end
            end
            PH_SPI_DATA: begin
               reg_in = {reg_ff[30:0], cmd};
               if (cnt_ff != 7'd0) begin
                  cnt_in = cnt_ff - 7'd1;
               end else begin
                  phase_in = PH_PAUSE;
                  cnt_in   = 7'd2;
                  valid_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // state registers, advanced once per accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         tx_ff     <= {40{1'b1}};
         cnt_ff    <= 7'd0;
         kind_ff   <= 3'd0;
         hidx_ff   <= 6'd0;
         idx_ff    <= 6'd0;
         reg_ff    <= 32'd0;
         status_ff <= 15'd0;
         crc_ff    <= 7'd0;
         clr_ff    <= 1'b1;
         snap_ff   <= 7'd0;
         crx_ff    <= 7'd0;
         cs_ff     <= 1'b1;
         dir_ff    <= 1'b1;
         wdog_ff   <= 1'b0;
         valid_ff  <= 1'b0;
         err_ff    <= ERR_NONE;
      end else if (step) begin
         phase_ff  <= phase_in;
         tx_ff     <= tx_in;
         cnt_ff    <= cnt_in;
         kind_ff   <= kind_in;
         hidx_ff   <= hidx_in;
         idx_ff    <= idx_in;
         reg_ff    <= reg_in;
         status_ff <= status_in;
         crc_ff    <= crc_in;
         clr_ff    <= clr_in;
         snap_ff   <= snap_in;
         crx_ff    <= crx_in;
         cs_ff     <= cs_in;
         dir_ff    <= dir_in;
         wdog_ff   <= wdog_in;
         valid_ff  <= valid_in;
         err_ff    <= err_in;
      end
   end

endmodule

FILE: tb/sd_command_line_engine_test.sv
// self-checking testbench for sd_command_line_engine: a card model answers commands,
// an in-house predictor of the line engine checks every result beat
// depends on sdcle_pkg and the engine rtl only
`timescale 1ns / 1ps

module sd_command_line_engine_test;
   import sdcle_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;

   // response kinds not named in the package
   localparam logic [2:0] KIND_R1   = 3'd0;
   localparam logic [2:0] KIND_R6   = 3'd3;
   localparam logic [2:0] KIND_ODD  = 3'd7;

   // sequencer phases of the line engine
   typedef enum logic [3:0] {
      ST_IDLE     = 4'd0,
      ST_TX_BODY  = 4'd1,
      ST_TX_CRC   = 4'd2,
      ST_TX_STOP  = 4'd3,
      ST_WAIT     = 4'd4,
      ST_TRANS    = 4'd5,
      ST_MIRROR   = 4'd6,
      ST_REG      = 4'd7,
      ST_LONG     = 4'd8,
      ST_RX_CRC   = 4'd9,
      ST_RX_STOP  = 4'd10,
      ST_SPI_R1   = 4'd11,
      ST_SPI_R2   = 4'd12,
      ST_SPI_DATA = 4'd13,
      ST_PAUSE    = 4'd15
   } line_phase_type;

   // how the simulated card misbehaves for one command
   typedef enum int {
      FAULT_NONE,
      FAULT_SILENT,
      FAULT_BAD_TRANS,
      FAULT_BAD_STOP
   } card_fault_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;
   logic                csr_valid;
   logic                csr_ready;
   logic                csr_data;

   // predicted engine state
   line_phase_type eng_phase;
   logic [39:0] eng_tx;
   logic [6:0]  eng_count;
   logic [2:0]  eng_kind;
   logic [5:0]  eng_index_sent;
   logic [5:0]  eng_index_rx;
   logic [31:0] eng_word;
   logic [14:0] eng_status;
   logic [6:0]  eng_crc;
   logic        eng_crc_clear;
   logic [6:0]  eng_crc_snap;
   logic [6:0]  eng_crc_rx;
   logic        eng_cs;
   logic        eng_out_en;
   logic        eng_wdog;
   logic        eng_valid;
   logic [1:0]  eng_err;
   logic        eng_spi;

   // results still owed by the engine, oldest first
   sdcle_out_type line_expect_q[$];
   sdcle_out_type got_beat;
   sdcle_out_type want_beat;

   // simulated card and sender state
   int             card_delay;
   card_fault_type card_fault;
   int             noise_pct = 0;
   logic           beat_held = 1'b0;
   int             idle_left = 1;
   int             calm_left = 0;

   // tallies
   int fail_count = 0;
   int beat_total = 0;
   int command_total = 0;
   int frames_done = 0;
   int err_tally[4] = '{0, 0, 0, 0};
   int idle_cycles = 0;
   int rsp_calm = 0;
   int rsp_stall = 0;
   int roll_rsp;

   sd_command_line_engine i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   // crc7, x^7+x^3+1, one bit in
   function automatic logic [6:0] crc7_next(input logic [6:0] crc, input logic din);
      logic fb;
      fb = crc[6] ^ din;
      return {crc[5:3], crc[2] ^ fb, crc[1:0], fb};
   endfunction

   function automatic void engine_reset();
      eng_phase      = ST_IDLE;
      eng_tx         = '1;
      eng_count      = '0;
      eng_kind       = '0;
      eng_index_sent = '0;
      eng_index_rx   = '0;
      eng_word       = '0;
      eng_status     = '0;
      eng_crc        = '0;
      eng_crc_clear  = 1'b1;
      eng_crc_snap   = '0;
      eng_crc_rx     = '0;
      eng_cs         = 1'b1;
      eng_out_en     = 1'b1;
      eng_wdog       = 1'b0;
      eng_valid      = 1'b0;
      eng_err        = ERR_NONE;
      eng_spi        = 1'b0;
   endfunction

   // one system cycle of the engine: returns the outputs seen before the update
   function automatic sdcle_out_type engine_step(input sdcle_in_type b);
      sdcle_out_type  o;
      line_phase_type ph;
      logic           feed;
      logic           dbit;
      logic [6:0]     crc_w;
      ph = eng_phase;
      o.cmd_out        = eng_tx[39];
      o.drive_enable   = eng_out_en;
      o.chip_select    = eng_cs;
      o.req_accept     = b.sclk_fall && ph == ST_IDLE && !b.error_pending;
      o.resp_avail     = eng_valid;
      o.resp_index     = eng_index_rx;
      o.resp_register  = eng_word;
      o.crc_received   = eng_crc_rx;
      o.crc_computed   = eng_crc_snap;
      o.spi_status     = eng_status;
      o.timeout_enable = eng_wdog;
      o.error_code     = eng_err;

      // crc feed decided on the phase before the update
      feed = 1'b0;
      if (b.sclk_fall) begin
         feed = (ph == ST_TX_BODY);
      end else if (b.sclk_rise) begin
         feed = (ph == ST_WAIT && !b.cmd_in && !eng_spi) || ph == ST_TRANS ||
                ph == ST_MIRROR || ph == ST_REG;
      end
      dbit  = (ph < ST_WAIT || ph == ST_PAUSE) ? eng_tx[39] : b.cmd_in;
      crc_w = eng_crc_clear ? 7'd0 : eng_crc;
      if (feed) begin
         crc_w = crc7_next(crc_w, dbit);
      end

      eng_err = ERR_NONE;
      if (b.resp_ack) begin
         eng_valid = 1'b0;
      end

      // falling edge: request side
      if (b.sclk_fall) begin
         case (ph)
            ST_IDLE: begin
               eng_tx        = b.force_low ? 40'd0 : {40{1'b1}};
               eng_wdog      = 1'b0;
               eng_cs        = 1'b1;
               eng_out_en    = 1'b1;
               eng_crc_clear = 1'b1;
               if (!b.error_pending && b.req_valid) begin
                  eng_cs         = 1'b0;
                  eng_index_sent = b.req_index;
                  eng_kind       = b.req_resp_kind;
                  eng_tx         = {1'b0, 1'b1, b.req_index, b.req_argument};
                  eng_count      = 7'd39;
                  eng_crc_clear  = 1'b0;
                  eng_phase      = ST_TX_BODY;
               end
            end
            ST_TX_BODY: begin
               eng_tx = {eng_tx[38:0], 1'b1};
               if (eng_count != 0) begin
                  eng_count = eng_count - 7'd1;
               end else begin
                  eng_phase      = ST_TX_CRC;
                  eng_crc_snap   = crc_w;
                  eng_tx[39:32]  = {crc_w, 1'b1};
                  eng_count      = 7'd6;
                  eng_crc_clear  = 1'b1;
               end
            end
            ST_TX_CRC: begin
               eng_tx = {eng_tx[38:0], 1'b1};
               if (eng_count != 0) begin
                  eng_count = eng_count - 7'd1;
               end else begin
                  eng_phase = ST_TX_STOP;
               end
            end
            ST_TX_STOP: begin
               eng_phase     = ST_WAIT;
               eng_out_en    = 1'b0;
               eng_wdog      = 1'b1;
               eng_crc_clear = 1'b0;
            end
            ST_PAUSE: begin
               eng_crc_clear = 1'b1;
               eng_cs        = 1'b1;
               eng_out_en    = 1'b1;
               if (eng_count != 0) begin
                  eng_count = eng_count - 7'd1;
               end else begin
                  eng_phase = ST_IDLE;
               end
            end
            default: ;
         endcase
      // rising edge: response side
      end else if (b.sclk_rise) begin
         case (ph)
            ST_WAIT: begin
               if (!b.cmd_in) begin
                  if (!eng_spi) begin
                     eng_phase = ST_TRANS;
                  end else begin
                     eng_phase    = ST_SPI_R1;
                     eng_count    = 7'd6;
                     eng_index_rx = eng_index_sent;
                     eng_status   = '0;
                     eng_word     = '0;
                  end
               end else if (b.timeout_tick) begin
                  eng_wdog  = 1'b0;
                  eng_valid = 1'b1;
                  eng_err   = ERR_NO_RESP;
                  eng_phase = ST_IDLE;
               end
            end
            ST_TRANS: begin
               if (!b.cmd_in) begin
                  eng_phase    = ST_MIRROR;
                  eng_index_rx = '0;
                  eng_count    = 7'd5;
               end else begin
                  eng_err   = ERR_BAD_START;
                  eng_phase = ST_IDLE;
                  eng_valid = 1'b1;
               end
            end
            ST_MIRROR: begin
               eng_index_rx = {eng_index_rx[4:0], b.cmd_in};
               if (eng_count != 0) begin
                  eng_count = eng_count - 7'd1;
               end else if (eng_kind == KIND_R2) begin
                  eng_count = 7'd119;
                  eng_phase = ST_LONG;
               end else begin
                  eng_count = 7'd31;
                  eng_phase = ST_REG;
               end
            end
            ST_REG, ST_LONG: begin
               if (ph == ST_REG) begin
                  eng_word = {eng_word[30:0], b.cmd_in};
               end
               if (eng_count != 0) begin
                  eng_count = eng_count - 7'd1;
               end else begin
                  eng_crc_snap = crc_w;
                  eng_count    = 7'd6;
                  eng_phase    = ST_RX_CRC;
               end
            end
            ST_RX_CRC: begin
               eng_crc_rx = {eng_crc_rx[5:0], b.cmd_in};
               if (eng_count != 0) begin
                  eng_count = eng_count - 7'd1;
               end else begin
                  eng_phase = ST_RX_STOP;
               end
            end
            ST_RX_STOP: begin
               if (!b.cmd_in) begin
                  eng_err = ERR_BAD_STOP;
               end
               eng_phase = ST_PAUSE;
               eng_count = 7'd2;
               eng_valid = 1'b1;
            end
            ST_SPI_R1: begin
               eng_status[14:8] = {eng_status[13:8], b.cmd_in};
               if (eng_count != 0) begin
                  eng_count = eng_count - 7'd1;
               end else if (eng_kind == KIND_R2) begin
                  eng_count = 7'd7;
                  eng_phase = ST_SPI_R2;
               end else if (eng_kind == KIND_R3 || eng_kind == KIND_R7) begin
                  eng_count = 7'd31;
                  eng_phase = ST_SPI_DATA;
               end else begin
                  eng_phase = ST_PAUSE;
                  eng_count = 7'd2;
                  eng_valid = 1'b1;
               end
            end
            ST_SPI_R2, ST_SPI_DATA: begin
               if (ph == ST_SPI_R2) begin
                  eng_status[7:0] = {eng_status[6:0], b.cmd_in};
               end else begin
                  eng_word = {eng_word[30:0], b.cmd_in};
               end
               if (eng_count != 0) begin
                  eng_count = eng_count - 7'd1;
               end else begin
                  eng_phase = ST_PAUSE;
                  eng_count = 7'd2;
                  eng_valid = 1'b1;
               end
            end
            default: ;
         endcase
      end

      eng_crc = crc_w;
      return o;
   endfunction

   function automatic logic [ReqDataW-1:0] pack_request(input sdcle_in_type b);
      logic [ReqDataW-1:0] d;
      d        = '0;
      d[0]     = b.sclk_rise;
      d[1]     = b.sclk_fall;
      d[2]     = b.cmd_in;
      d[3]     = b.error_pending;
      d[4]     = b.timeout_tick;
      d[5]     = b.force_low;
      d[6]     = b.req_valid;
      d[12:7]  = b.req_index;
      d[44:13] = b.req_argument;
      d[47:45] = b.req_resp_kind;
      d[48]    = b.resp_ack;
      return d;
   endfunction

   function automatic sdcle_out_type unpack_result(input logic [RspDataW-1:0] d);
      sdcle_out_type r;
      r.cmd_out        = d[0];
      r.drive_enable   = d[1];
      r.chip_select    = d[2];
      r.req_accept     = d[3];
      r.resp_avail     = d[4];
      r.resp_index     = d[10:5];
      r.resp_register  = d[42:11];
      r.crc_received   = d[49:43];
      r.crc_computed   = d[56:50];
      r.spi_status     = d[71:57];
      r.timeout_enable = d[72];
      r.error_code     = d[74:73];
      return r;
   endfunction

   function automatic void check_field(input string fname, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         fail_count++;
         if (fail_count <= 30) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
         end
      end
   endfunction

   // sender gaps: mostly none or short, a few long, now and then a gapless stretch
   function automatic int pick_gap();
      int roll;
      if (calm_left != 0) begin
         calm_left--;
         return 0;
      end
      roll = $urandom_range(0, 999);
      if (roll < 5) begin
         calm_left = $urandom_range(50, 200);
         return 0;
      end
      if (roll < 600) return 0;
      if (roll < 900) return $urandom_range(1, 3);
      if (roll < 990) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // level the card puts on the cmd line for this beat
   function automatic logic card_level(input logic rise_only);
      if (!rise_only) return 1'($urandom_range(0, 1));
      case (eng_phase)
         ST_WAIT: begin
            if (card_fault == FAULT_SILENT) return 1'b1;
            if (card_delay > 0) begin
               card_delay--;
               return 1'b1;
            end
            return 1'b0;
         end
         ST_TRANS:   return card_fault == FAULT_BAD_TRANS;
         ST_RX_STOP: return card_fault != FAULT_BAD_STOP;
         default:    return 1'($urandom_range(0, 1));
      endcase
   endfunction

   // send one beat and record what the engine owes for it
   task automatic send_beat(input sdcle_in_type b);
      line_phase_type was;
      if (!beat_held) begin
         repeat (idle_left) @(posedge clock);
      end
      req_tdata  <= pack_request(b);
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      was = eng_phase;
      line_expect_q.push_back(engine_step(b));
      beat_total++;
      if (eng_err != ERR_NONE) err_tally[eng_err]++;
      if (eng_phase == ST_PAUSE && was != ST_PAUSE) frames_done++;
      idle_left = pick_gap();
      beat_held = (idle_left == 0);
      if (!beat_held) begin
         req_tvalid <= 1'b0;
      end
   endtask

   task automatic line_quiet();
      if (beat_held) begin
         req_tvalid <= 1'b0;
         beat_held = 1'b0;
         idle_left = 1;
      end
   endtask

   // one system cycle on the line: falling edges while sending or pausing, rising
   // edges while listening, now and then the edge that the engine ignores
   task automatic line_beat(input logic offer, input logic [5:0] idx,
                            input logic [31:0] arg, input logic [2:0] kind);
      sdcle_in_type b;
      logic         tx_side;
      b       = '0;
      tx_side = (eng_phase <= ST_TX_STOP || eng_phase == ST_PAUSE);
      if ($urandom_range(0, 15) == 0) begin
         tx_side = !tx_side;
      end
      b.sclk_fall = tx_side;
      b.sclk_rise = !tx_side;
      if (noise_pct != 0 && $urandom_range(0, 99) < noise_pct) begin
         case ($urandom_range(0, 2))
            0: begin
               b.sclk_fall = 1'b0;
               b.sclk_rise = 1'b0;
            end
            1: begin
               b.sclk_fall = 1'b1;
               b.sclk_rise = 1'b1;
            end
            default: begin
               b.sclk_fall = 1'($urandom_range(0, 1));
               b.sclk_rise = 1'($urandom_range(0, 1));
            end
         endcase
      end
      b.cmd_in        = card_level(b.sclk_rise && !b.sclk_fall);
      b.error_pending = ($urandom_range(0, 99) < 3);
      if (card_fault == FAULT_SILENT) begin
         b.timeout_tick = ($urandom_range(0, 3) == 0);
      end else begin
         b.timeout_tick = (noise_pct != 0 && $urandom_range(0, 49) == 0);
      end
      b.force_low     = 1'($urandom_range(0, 1));
      b.req_valid     = offer;
      b.req_index     = idx;
      b.req_argument  = arg;
      b.req_resp_kind = kind;
      b.resp_ack      = ($urandom_range(0, 2) == 0);
      send_beat(b);
   endtask

   // issue one command and clock the line until the engine is back in idle
   task automatic run_command(input logic [5:0] idx, input logic [31:0] arg,
                              input logic [2:0] kind, input int delay,
                              input card_fault_type fault);
      line_phase_type was;
      logic           issued;
      card_delay = delay;
      card_fault = fault;
      issued     = 1'b0;
      while (!issued) begin
         was = eng_phase;
         line_beat(1'b1, idx, arg, kind);
         issued = (was == ST_IDLE && eng_phase == ST_TX_BODY);
      end
      command_total++;
      while (eng_phase != ST_IDLE) begin
         line_beat(1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)), $urandom,
                   3'($urandom_range(0, 7)));
      end
      card_fault = FAULT_NONE;
   endtask

   // register write, only with nothing in flight
   task automatic set_line_mode(input logic spi);
      line_quiet();
      while (line_expect_q.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_data  <= spi;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      eng_spi = spi;
   endtask

   // idle-state beats: field extremes, blocked request, both edges, forced low line
   task automatic test_idle_beats();
      sdcle_in_type b;
      b = '0;
      send_beat(b);
      b = '1;
      send_beat(b);
      b = '0;
      b.sclk_fall = 1'b1;
      b.force_low = 1'b1;
      send_beat(b);
      b.force_low = 1'b0;
      b.resp_ack  = 1'b1;
      send_beat(b);
      b = '0;
      b.sclk_fall = 1'b1;
      b.sclk_rise = 1'b1;
      b.cmd_in    = 1'b1;
      send_beat(b);
      b = '0;
      b.sclk_rise = 1'b1;
      send_beat(b);
   endtask

   // native framing: unlisted kind on the short frame, then the long frame
   task automatic test_sd_framing();
      set_line_mode(1'b0);
      noise_pct = 0;
      run_command(6'd55, 32'h5A5A_A5A5, KIND_ODD, 0, FAULT_NONE);
      run_command(6'h3F, 32'hFFFF_FFFF, KIND_R2, 2, FAULT_NONE);
   endtask

   // native framing, no response, bad transmission bit, bad end bit
   task automatic test_sd_errors();
      run_command(6'd17, 32'h1234_5678, KIND_R1, 0, FAULT_SILENT);
      run_command(6'd2, 32'h0000_0000, KIND_R2, 1, FAULT_BAD_TRANS);
      run_command(6'd8, 32'h0000_01AA, KIND_R7, 0, FAULT_BAD_STOP);
   endtask

   // spi framing with the status byte after r1
   task automatic test_spi_framing();
      set_line_mode(1'b1);
      run_command(6'd9, 32'hFFFF_FFFF, KIND_R2, 0, FAULT_NONE);
   endtask

   // random commands, mostly well-formed, some with card faults and odd edges
   task automatic test_random_traffic(input logic spi, input int commands);
      int             n;
      int             roll;
      logic [31:0]    arg;
      card_fault_type fault;
      set_line_mode(spi);
      for (n = 0; n < commands; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 6) fault = FAULT_SILENT;
         else if (roll < 11) fault = FAULT_BAD_TRANS;
         else if (roll < 16) fault = FAULT_BAD_STOP;
         else fault = FAULT_NONE;
         roll = $urandom_range(0, 9);
         if (roll == 0) arg = '0;
         else if (roll == 1) arg = '1;
         else arg = $urandom;
         noise_pct = ($urandom_range(0, 3) == 0) ? 6 : 0;
         run_command(6'($urandom_range(0, 63)), arg, 3'($urandom_range(0, 7)),
                     ($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3),
                     fault);
         // idle line between commands
         while ($urandom_range(0, 3) == 0) begin
            line_beat(1'b0, 6'($urandom_range(0, 63)), $urandom, 3'($urandom_range(0, 7)));
         end
      end
      noise_pct = 0;
   endtask

   // result side backpressure
   always @(posedge clock) begin
      if (rsp_calm != 0) begin
         rsp_calm--;
         rsp_tready <= 1'b1;
      end else if (rsp_stall != 0) begin
         rsp_stall--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         roll_rsp = $urandom_range(0, 999);
         if (roll_rsp < 3) rsp_calm = $urandom_range(100, 300);
         else if (roll_rsp < 90) rsp_stall = $urandom_range(1, 3);
         else if (roll_rsp < 100) rsp_stall = $urandom_range(8, 40);
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (line_expect_q.size() == 0) begin
            fail_count++;
            $display("%0t ns: result beat with nothing expected, expected none, actual %h",
                     $time, rsp_tdata);
         end else begin
            got_beat  = unpack_result(rsp_tdata);
            want_beat = line_expect_q.pop_front();
            check_field("cmd_out", want_beat.cmd_out, got_beat.cmd_out);
            check_field("drive_enable", want_beat.drive_enable, got_beat.drive_enable);
            check_field("chip_select", want_beat.chip_select, got_beat.chip_select);
            check_field("req_accept", want_beat.req_accept, got_beat.req_accept);
            check_field("resp_avail", want_beat.resp_avail, got_beat.resp_avail);
            check_field("resp_index", want_beat.resp_index, got_beat.resp_index);
            check_field("resp_register", want_beat.resp_register, got_beat.resp_register);
            check_field("crc_received", want_beat.crc_received, got_beat.crc_received);
            check_field("crc_computed", want_beat.crc_computed, got_beat.crc_computed);
            check_field("spi_status", want_beat.spi_status, got_beat.spi_status);
            check_field("timeout_enable", want_beat.timeout_enable, got_beat.timeout_enable);
            check_field("error_code", want_beat.error_code, got_beat.error_code);
         end
      end
   end

   // watchdog on handshake activity
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t ns: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("simulation failed");
         $finish;
      end
   end

   // test sequence
   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_data   = 1'b0;
      engine_reset();
      card_fault = FAULT_NONE;
      card_delay = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_idle_beats();
      test_sd_framing();
      test_sd_errors();
      test_spi_framing();
      test_random_traffic(1'b1, 2);

      line_quiet();
      while (line_expect_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("covered %0d commands in %0d beats, native and spi framing, %0d frames received",
               command_total, beat_total, frames_done);
      $display("errors raised: %0d no response, %0d bad start, %0d bad stop; %0d mismatches",
               err_tally[ERR_NO_RESP], err_tally[ERR_BAD_START], err_tally[ERR_BAD_STOP],
               fail_count);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
